// File: sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic   enq_go;
        logic   deq_go;
        t_entry item;
    } t_cmd;

endpackage

// File: sv/sorted_priority_queue.sv
// Top level of the sorted priority queue built as a chain of cells.
//
// The queue holds up to 16 (value, priority) pairs, sorted highest priority
// first, with equal priorities served in arrival order. A request is taken
// in any cycle in which start is high; busy never rises, so one enqueue or
// dequeue is taken every cycle. Every request gives exactly one result, shown
// with o_strobe for one cycle on the cycle after the request; the receiver
// must take it then. All cells compare against the new priority in parallel
// and shift by one place, so the time to a result does not depend on the fill.
module sorted_priority_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_action,
    input  logic signed [31:0]  i_item_value,
    input  logic signed [31:0]  i_item_priority,
    output logic                o_strobe,
    output logic signed [31:0]  o_out_value,
    output logic signed [31:0]  o_out_priority,
    output logic                o_out_valid,
    output logic [4:0]          o_entry_count,
    output logic                o_is_empty,
    output logic [1:0]          o_status
);

    localparam int CAP = spq_pkg::CAPACITY;

    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;
    logic                      r_strobe;
    spq_pkg::t_entry           r_out;
    logic                      r_out_valid;
    logic [spq_pkg::CNT_W-1:0] r_out_count;
    spq_pkg::t_status          r_status;
    spq_pkg::t_status          n_status;

    spq_pkg::t_cmd   cmd;
    spq_pkg::t_entry cell_data [CAP];
    logic            cell_keep [CAP];
    logic            is_full;
    logic            is_none;
    logic            take;

    assign busy    = 1'b0;
    assign take    = start && !busy;
    assign is_full = (r_count == spq_pkg::CNT_W'(CAP));
    assign is_none = (r_count == '0);

    assign cmd.enq_go     = take && (i_action == spq_pkg::ACT_ENQUEUE) && !is_full;
    assign cmd.deq_go     = take && (i_action == spq_pkg::ACT_DEQUEUE) && !is_none;
    assign cmd.item.value = i_item_value;
    assign cmd.item.prio  = i_item_priority;

    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++) begin : g_cell
            logic            left_keep;
            spq_pkg::t_entry left_data;
            spq_pkg::t_entry right_data;

            if (gi == 0) begin : g_first
                assign left_keep = 1'b1;
                assign left_data = cmd.item;
            end else begin : g_mid
                assign left_keep = cell_keep[gi-1];
                assign left_data = cell_data[gi-1];
            end

            if (gi == CAP - 1) begin : g_last
                assign right_data = cell_data[gi];
            end else begin : g_inner
                assign right_data = cell_data[gi+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cmd),
                .i_occupied   (spq_pkg::CNT_W'(gi) < r_count),
                .i_left_keep  (left_keep),
                .i_left_data  (left_data),
                .i_right_data (right_data),
                .o_keep       (cell_keep[gi]),
                .o_data       (cell_data[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        if (cmd.enq_go) begin
            n_count = r_count + spq_pkg::CNT_W'(1);
        end else if (cmd.deq_go) begin
            n_count = r_count - spq_pkg::CNT_W'(1);
        end
        if (take && (i_action == spq_pkg::ACT_ENQUEUE) && is_full) begin
            n_status = spq_pkg::ST_FULL;
        end else if (take && (i_action == spq_pkg::ACT_DEQUEUE) && is_none) begin
            n_status = spq_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= take;
        end
        r_out_valid <= cmd.deq_go;
        r_out       <= cmd.deq_go ? cell_data[0] : '0;
        r_out_count <= n_count;
        r_status    <= n_status;
    end

    assign o_strobe       = r_strobe;
    assign o_out_value    = r_out.value;
    assign o_out_priority = r_out.prio;
    assign o_out_valid    = r_out_valid;
    assign o_entry_count  = 5'(r_out_count);
    assign o_is_empty     = (r_out_count == '0);
    assign o_status       = r_status;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_strobe)
        else $error("result strobe missing after request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(CAP))
        else $error("stored count exceeds capacity");

    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out_valid) |-> (o_status == spq_pkg::ST_OK))
        else $error("returned pair with error status");

    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (i_action == spq_pkg::ACT_DEQUEUE) && is_none)
        |=> (!o_out_valid && o_is_empty))
        else $error("dequeue on empty returned a pair");

endmodule

// File: sv/spq_cell.sv
// One storage cell of the sorted queue chain.
module spq_cell (
    input  logic            i_clk,
    input  spq_pkg::t_cmd   i_cmd,
    input  logic            i_occupied,
    input  logic            i_left_keep,
    input  spq_pkg::t_entry i_left_data,
    input  spq_pkg::t_entry i_right_data,
    output logic            o_keep,
    output spq_pkg::t_entry o_data
);

    spq_pkg::t_entry r_data;
    spq_pkg::t_entry n_data;

    assign o_keep = i_occupied && (r_data.prio >= i_cmd.item.prio);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.enq_go && !o_keep) begin
            n_data = i_left_keep ? i_cmd.item : i_left_data;
        end else if (i_cmd.deq_go) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule
